### rtl/priority_process_scheduler_macros.svh
// ----------------------------------------------------------------------------
// Priority process scheduler assertion macros
// Shared concurrent assertion forms, clocked on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_PROCESS_SCHEDULER_MACROS_SVH
`define PRIORITY_PROCESS_SCHEDULER_MACROS_SVH

// same-cycle implication
`define PPS_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pps assertion failed");

// next-cycle implication
`define PPS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pps assertion failed");

`endif

### rtl/pps_pkg.sv
// ----------------------------------------------------------------------------
// Priority process scheduler package
// Queue depth, entry and command types, request kinds and status codes.
// ----------------------------------------------------------------------------
package pps_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      KIND_ADD = 1'b0,
      KIND_RUN = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      ST_ADDED    = 3'd0,
      ST_FULL     = 3'd1,
      ST_ZERO     = 3'd2,
      ST_REQUEUED = 3'd3,
      ST_FINISHED = 3'd4,
      ST_EMPTY    = 3'd5
   } status_type;

   typedef struct packed {
      logic              valid;
      logic [7:0]        id;
      logic [15:0]       ticks;
      logic signed [15:0] prio;
   } entry_type;

   typedef struct packed {
      logic      shift;   // drop head, move entries toward head
      logic      ins;     // sorted insert of item
      entry_type item;
   } cmd_type;

endpackage

### rtl/pps_cell.sv
// ----------------------------------------------------------------------------
// Priority process scheduler queue cell
// One slot of the sorted queue; shifts toward the head and takes the insert.
// ----------------------------------------------------------------------------
module pps_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  pps_pkg::cmd_type   cmd,
   input  pps_pkg::entry_type prev_base,
   input  logic               prev_keep,
   input  pps_pkg::entry_type next_own,
   output pps_pkg::entry_type own,
   output pps_pkg::entry_type base,
   output logic               keep
);

   pps_pkg::entry_type entry_ff;
   pps_pkg::entry_type entry_in;

   assign own = entry_ff;

   always_comb begin
      base = cmd.shift ? next_own : entry_ff;
      keep = base.valid && ($signed(base.prio) >= $signed(cmd.item.prio));
      if (!cmd.ins) begin
         entry_in = base;
      end else if (keep) begin
         entry_in = base;
      end else if (prev_keep) begin
         entry_in = cmd.item;
      end else begin
         entry_in = prev_base;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else if (load) begin
         entry_ff <= entry_in;
      end
   end

endmodule

### rtl/priority_process_scheduler.sv
// ----------------------------------------------------------------------------
// Priority process scheduler
// Sorted ready queue in a row of cells; add a process or run the head one tick.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  req     | in  | req_tvalid/tready  | tuser kind, tdata id/time/priority
//  rsp     | out | rsp_tvalid/tready  | tuser status, tdata id/time/prio/count
//
//  One request per cycle while req_tready is high; its response is registered in the cycle after the accept.
//  Every cell updates in the accept cycle from its neighbors and the command.
//  req_tready is low only while a response waits and rsp_tready is low.
//  Synchronous reset empties the queue by clearing the cell valid bits.
// ----------------------------------------------------------------------------
module priority_process_scheduler (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,   // [0] kind
   input  logic [39:0] req_tdata,   // [7:0] proc_id, [23:8] run_time, [39:24] priority_req
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [2:0]  rsp_tuser,   // [2:0] status
   output logic [47:0] rsp_tdata    // [7:0] run_id, [23:8] remaining_time,
                                    // [39:24] new_priority, [44:40] queue_count
);

   localparam int N = pps_pkg::QUEUE_DEPTH;
   localparam int W = pps_pkg::CNT_W;

   pps_pkg::entry_type own  [N];
   pps_pkg::entry_type base [N];
   logic               keep [N];
   pps_pkg::cmd_type   cmd;

   logic                   accept;
   logic [W-1:0]           count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   pps_pkg::status_type    status_ff, status_in;
   logic [7:0]             run_id_ff, run_id_in;
   logic [15:0]            rtime_ff, rtime_in;
   logic [15:0]            rprio_ff, rprio_in;
   logic [4:0]             qcount_ff, qcount_in;
   pps_pkg::entry_type     head_run;
   logic [31:0]            count_wide;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   genvar g;
   generate
      for (g = 0; g < N; g++) begin : g_cell
         pps_pkg::entry_type prev_base_w;
         pps_pkg::entry_type next_own_w;
         logic               prev_keep_w;
         if (g == 0) begin : g_first
            assign prev_base_w = '0;
            assign prev_keep_w = 1'b1;
         end else begin : g_mid
            assign prev_base_w = base[g-1];
            assign prev_keep_w = keep[g-1];
         end
         if (g == N - 1) begin : g_last
            assign next_own_w = '0;
         end else begin : g_body
            assign next_own_w = own[g+1];
         end
         pps_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .load      (accept),
            .cmd       (cmd),
            .prev_base (prev_base_w),
            .prev_keep (prev_keep_w),
            .next_own  (next_own_w),
            .own       (own[g]),
            .base      (base[g]),
            .keep      (keep[g])
         );
      end
   endgenerate

   always_comb begin
      head_run       = own[0];
      head_run.ticks = own[0].ticks - 16'd1;
      if (own[0].prio != 16'sh8000) begin
         head_run.prio = own[0].prio - 16'sd1;
      end

      cmd.shift      = 1'b0;
      cmd.ins        = 1'b0;
      cmd.item.valid = 1'b1;
      cmd.item.id    = req_tdata[7:0];
      cmd.item.ticks = req_tdata[23:8];
      cmd.item.prio  = req_tdata[39:24];
      count_in       = count_ff;
      status_in      = pps_pkg::ST_ADDED;
      run_id_in      = 8'd0;
      rtime_in       = 16'd0;
      rprio_in       = 16'd0;

      if (pps_pkg::kind_type'(req_tuser) == pps_pkg::KIND_ADD) begin
         if (req_tdata[23:8] == 16'd0) begin
            status_in = pps_pkg::ST_ZERO;
         end else if (count_ff == W'(N)) begin
            status_in = pps_pkg::ST_FULL;
         end else begin
            cmd.ins  = 1'b1;
            count_in = count_ff + W'(1);
         end
      end else if (count_ff == '0) begin
         status_in = pps_pkg::ST_EMPTY;
      end else begin
         cmd.shift = 1'b1;
         run_id_in = head_run.id;
         rtime_in  = head_run.ticks;
         rprio_in  = head_run.prio;
         if (head_run.ticks == 16'd0) begin
            status_in = pps_pkg::ST_FINISHED;
            count_in  = count_ff - W'(1);
         end else begin
            status_in = pps_pkg::ST_REQUEUED;
            cmd.ins   = 1'b1;
            cmd.item  = head_run;
         end
      end

      count_wide   = 32'(count_in);
      qcount_in    = count_wide[4:0];
      rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         run_id_ff <= run_id_in;
         rtime_ff  <= rtime_in;
         rprio_ff  <= rprio_in;
         qcount_ff <= qcount_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {3'b000, qcount_ff, rprio_ff, rtime_ff, run_id_ff};

endmodule

### rtl/pps_checker.sv
// ----------------------------------------------------------------------------
// Priority process scheduler port checker
// Port-level checks on response timing and status consistency.
// ----------------------------------------------------------------------------
`include "priority_process_scheduler_macros.svh"

module pps_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tuser,
   input logic [39:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [2:0]  rsp_tuser,
   input logic [47:0] rsp_tdata
);

   logic rsp_stall;
   logic rsp_empty;
   logic rsp_full;

   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_empty = rsp_tvalid && (rsp_tuser == pps_pkg::ST_EMPTY);
   assign rsp_full  = rsp_tvalid && (rsp_tuser == pps_pkg::ST_FULL);

   `PPS_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
   `PPS_ASSERT_NEXT(a_req_gives_rsp, req_tvalid && req_tready, rsp_tvalid)
   `PPS_ASSERT_SAME(a_empty_zero, rsp_empty, rsp_tdata[44:0] == 45'd0)
   `PPS_ASSERT_SAME(a_full_count, rsp_full, rsp_tdata[44:40] == 5'(pps_pkg::QUEUE_DEPTH))

endmodule

bind priority_process_scheduler pps_checker u_pps_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser),
   .rsp_tdata  (rsp_tdata)
);

### sim/priority_process_scheduler_tb.sv
// ----------------------------------------------------------------------------
// Priority process scheduler testbench
// Streams add and run beats into the scheduler, tracks the sorted ready queue
// alongside it and checks every response beat field by field, with random
// idle cycles on both channels and one long response hold-off.
// ----------------------------------------------------------------------------
module priority_process_scheduler_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned IDLE_LIMIT = 4000;
   localparam int unsigned RANDOM_ITEMS = 1100;
   localparam logic signed [15:0] PRIO_FLOOR = 16'sh8000;
   localparam logic signed [15:0] PRIO_CEIL = 16'sh7fff;

   typedef struct {
      pps_pkg::kind_type  kind;
      logic [7:0]         id;
      logic [15:0]        ticks;
      logic signed [15:0] prio;
   } sched_req_type;

   typedef struct {
      logic [7:0]         id;
      logic [15:0]        ticks;
      logic signed [15:0] prio;
   } proc_rec_type;

   typedef struct {
      pps_pkg::status_type status;
      logic [7:0]          run_id;
      logic [15:0]         remaining;
      logic signed [15:0]  prio;
      logic [4:0]          count;
   } sched_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic        req_tuser = 1'b0;    // [0] kind
   logic [39:0] req_tdata = '0;      // [7:0] proc_id, [23:8] run_time, [39:24] priority_req
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [2:0]  rsp_tuser;           // [2:0] status
   logic [47:0] rsp_tdata;           // [7:0] run_id, [23:8] remaining_time,
                                     // [39:24] new_priority, [44:40] queue_count

   sched_req_type    req_backlog[$];
   sched_result_type sched_due[$];
   proc_rec_type     ready_slot[pps_pkg::QUEUE_DEPTH];
   int unsigned      ready_cnt = 0;
   int unsigned      items_total = 0;
   int unsigned      reqs_accepted = 0;
   int unsigned      rsp_beats = 0;
   int unsigned      mismatches = 0;
   int unsigned      drv_gap = 0;
   int unsigned      drv_calm = 0;
   int unsigned      rsp_wait = 0;
   int unsigned      rsp_calm = 0;
   int unsigned      hold_left = 0;
   bit               hold_done = 1'b0;
   int unsigned      idle_cycles = 0;

   priority_process_scheduler dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void queue_req(pps_pkg::kind_type kind, logic [7:0] id,
                                     logic [15:0] ticks, logic signed [15:0] prio);
      sched_req_type r;
      r.kind = kind;
      r.id = id;
      r.ticks = ticks;
      r.prio = prio;
      req_backlog.push_back(r);
   endfunction

   // insert behind every entry of equal or higher priority
   function automatic void enqueue_sorted(proc_rec_type p);
      int unsigned pos;
      int unsigned i;
      pos = 0;
      while (pos < ready_cnt && ready_slot[pos].prio >= p.prio) pos++;
      for (i = ready_cnt; i > pos; i--) ready_slot[i] = ready_slot[i - 1];
      ready_slot[pos] = p;
      ready_cnt++;
   endfunction

   function automatic void scheduler_step(pps_pkg::kind_type kind, logic [7:0] id,
                                          logic [15:0] ticks, logic signed [15:0] prio);
      sched_result_type r;
      proc_rec_type     p;
      int unsigned      i;
      r.status = pps_pkg::ST_ADDED;
      r.run_id = '0;
      r.remaining = '0;
      r.prio = '0;
      if (kind == pps_pkg::KIND_ADD) begin
         if (ticks == 0) begin
            r.status = pps_pkg::ST_ZERO;
         end else if (ready_cnt >= pps_pkg::QUEUE_DEPTH) begin
            r.status = pps_pkg::ST_FULL;
         end else begin
            p.id = id;
            p.ticks = ticks;
            p.prio = prio;
            enqueue_sorted(p);
            r.status = pps_pkg::ST_ADDED;
         end
      end else if (ready_cnt == 0) begin
         r.status = pps_pkg::ST_EMPTY;
      end else begin
         p = ready_slot[0];
         for (i = 0; i + 1 < ready_cnt; i++) ready_slot[i] = ready_slot[i + 1];
         ready_cnt--;
         p.ticks = p.ticks - 16'd1;
         if (p.prio != PRIO_FLOOR) p.prio = p.prio - 16'sd1;
         if (p.ticks == 0) begin
            r.status = pps_pkg::ST_FINISHED;
         end else begin
            enqueue_sorted(p);
            r.status = pps_pkg::ST_REQUEUED;
         end
         r.run_id = p.id;
         r.remaining = p.ticks;
         r.prio = p.prio;
      end
      r.count = 5'(ready_cnt);
      sched_due.push_back(r);
   endfunction

   task automatic note_mismatch(string field, longint want, longint got);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
   endtask

   // driver
   always @(posedge clock) begin
      sched_req_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            scheduler_step(pps_pkg::kind_type'(req_tuser), req_tdata[7:0], req_tdata[23:8],
                           $signed(req_tdata[39:24]));
            reqs_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (drv_gap > 0) begin
               drv_gap--;
               req_tvalid <= 1'b0;
            end else if (req_backlog.size() > 0) begin
               nxt = req_backlog.pop_front();
               req_tuser <= nxt.kind;
               req_tdata <= {nxt.prio, nxt.ticks, nxt.id};
               req_tvalid <= 1'b1;
               if (drv_calm > 0) begin
                  drv_calm--;
               end else if ($urandom_range(0, 99) < 2) begin
                  drv_calm = $urandom_range(30, 80);
               end else begin
                  drv_gap = pick_gap();
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor and response back-pressure
   always @(posedge clock) begin
      sched_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_beats++;
            if (sched_due.size() == 0) begin
               $display("%0t: unexpected response beat, actual status %0d", $time, rsp_tuser);
               mismatches++;
            end else begin
               want = sched_due.pop_front();
               if (rsp_tuser !== want.status)
                  note_mismatch("status", want.status, rsp_tuser);
               if (rsp_tdata[7:0] !== want.run_id)
                  note_mismatch("run_id", want.run_id, rsp_tdata[7:0]);
               if (rsp_tdata[23:8] !== want.remaining)
                  note_mismatch("remaining_time", want.remaining, rsp_tdata[23:8]);
               if (rsp_tdata[39:24] !== want.prio)
                  note_mismatch("new_priority", want.prio, $signed(rsp_tdata[39:24]));
               if (rsp_tdata[44:40] !== want.count)
                  note_mismatch("queue_count", want.count, rsp_tdata[44:40]);
            end
         end
         if (!hold_done && rsp_beats >= 400) begin
            hold_done = 1'b1;
            hold_left = 150;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (rsp_calm > 0) begin
               rsp_calm--;
            end else if ($urandom_range(0, 99) < 2) begin
               rsp_calm = $urandom_range(30, 80);
            end else if ($urandom_range(0, 99) < 30) begin
               rsp_wait = pick_gap();
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
            $display("priority_process_scheduler test failed");
            $finish;
         end
      end
   end

   initial begin
      int unsigned i;
      int unsigned r;
      int unsigned add_pct;
      logic [15:0] ticks;
      logic signed [15:0] prio;

      // directed: empty run, zero time, extremes, ties, full, zero-while-full
      queue_req(pps_pkg::KIND_RUN, 8'd0, 16'd0, 16'sd0);
      queue_req(pps_pkg::KIND_ADD, 8'd255, 16'd0, PRIO_CEIL);
      queue_req(pps_pkg::KIND_ADD, 8'd0, 16'd1, PRIO_FLOOR);
      queue_req(pps_pkg::KIND_ADD, 8'd255, 16'hffff, PRIO_CEIL);
      queue_req(pps_pkg::KIND_ADD, 8'd1, 16'd2, PRIO_FLOOR);
      queue_req(pps_pkg::KIND_ADD, 8'd2, 16'd3, 16'sd5);
      queue_req(pps_pkg::KIND_ADD, 8'd3, 16'd3, 16'sd5);
      queue_req(pps_pkg::KIND_ADD, 8'd4, 16'd3, 16'sd5);
      for (i = 0; i < 10; i++)
         queue_req(pps_pkg::KIND_ADD, 8'(5 + i), 16'(1 + i % 3), 16'(int'(i) - 5));
      queue_req(pps_pkg::KIND_ADD, 8'd15, 16'd4, 16'sd100);
      queue_req(pps_pkg::KIND_ADD, 8'd16, 16'd0, 16'sd100);
      for (i = 0; i < 5; i++)
         queue_req(pps_pkg::KIND_RUN, 8'hff, 16'hffff, PRIO_FLOOR);

      // random: phases lean toward filling, draining, or hovering
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         case ((i / 60) % 3)
            0: add_pct = 65;
            1: add_pct = 20;
            default: add_pct = 45;
         endcase
         r = $urandom_range(0, 999);
         if (r < 30) ticks = 16'd0;
         else if (r < 870) ticks = 16'($urandom_range(1, 3));
         else if (r < 990) ticks = 16'($urandom_range(4, 20));
         else ticks = 16'($urandom_range(1, 65535));
         r = $urandom_range(0, 99);
         if (r < 40) prio = 16'($signed($urandom_range(0, 4)) - 2);
         else if (r < 50) prio = PRIO_FLOOR + 16'($urandom_range(0, 1));
         else if (r < 60) prio = PRIO_CEIL - 16'($urandom_range(0, 1));
         else prio = 16'($urandom());
         queue_req(($urandom_range(0, 99) < add_pct) ? pps_pkg::KIND_ADD : pps_pkg::KIND_RUN,
                   8'($urandom_range(0, 255)), ticks, prio);
      end
      items_total = req_backlog.size();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (reqs_accepted < items_total) @(posedge clock);
      while (sched_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("priority_process_scheduler test passed");
      end else begin
         $display("priority_process_scheduler test failed");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+rtl
rtl/pps_pkg.sv
rtl/pps_cell.sv
rtl/priority_process_scheduler.sv
rtl/pps_checker.sv
sim/priority_process_scheduler_tb.sv
